[design/rtt_pkg.sv]
// Shared codes, defaults and handshake structs for the repeating timer table
`timescale 1ns / 1ps

package rtt_pkg;

  // default sizes
  localparam int SLOTS_DEF         = 8;
  localparam int INTERVAL_BITS_DEF = 16;

  // field widths fixed by the item format
  localparam int CMD_W    = 2;
  localparam int ID_W     = 8;
  localparam int REPEAT_W = 16;
  localparam int IVAL_W   = 16;
  localparam int KIND_W   = 2;
  localparam int RCNT_W   = 4;

  // saturation limit of the removed-entry count
  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRY   = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_PRIME,
    ST_WALK,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;  // latch the incoming item
    logic add;     // append or reject, emit the add result
    logic prime;   // read the oldest entry
    logic step;    // process the entry in the read register
    logic finish;  // commit the new count, emit any closing result
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             empty;
    logic             out_free;
    logic             need_out;
    logic             at_end;
    logic             pend_valid;
  } stat_t;

endpackage

[design/rtt_ctrl.sv]
// Controller state machine for the repeating timer table
`timescale 1ns / 1ps

module rtt_ctrl import rtt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  stat_t            stat,
  output ctrl_t            ctrl
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_ADD:    state_next = ST_ADD;
            CMD_REMOVE: state_next = stat.empty ? ST_FINISH : ST_PRIME;
            CMD_TICK:   state_next = stat.empty ? ST_IDLE : ST_PRIME;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_PRIME: state_next = ST_WALK;
      ST_WALK: begin
        if ((!stat.need_out || stat.out_free) && stat.at_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free || (stat.op == CMD_TICK && !stat.pend_valid)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        // no item is taken while reset is held
        in_stall    = rst;
        ctrl.accept = in_valid && !rst;
      end
      ST_ADD:   ctrl.add   = stat.out_free;
      ST_PRIME: ctrl.prime = 1'b1;
      ST_WALK:  ctrl.step  = !stat.need_out || stat.out_free;
      ST_FINISH: begin
        ctrl.finish = stat.out_free || (stat.op == CMD_TICK && !stat.pend_valid);
      end
      default: begin
        ctrl     = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  // a walk only starts on a non-empty table
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && cmd == CMD_TICK && stat.empty) |=> state == ST_IDLE)
    else $error("tick on empty table left idle");

  // finishing always returns to idle
  assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> state == ST_IDLE)
    else $error("finish did not return to idle");

  // input is only taken while idle
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input open outside idle");

endmodule

[design/rtt_datapath.sv]
// Timer table storage, walk logic and result register
`timescale 1ns / 1ps

module rtt_datapath import rtt_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  output stat_t                      stat,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [IVAL_W-1:0]          interval_ms,
  input  logic signed [REPEAT_W-1:0] repeat_count,
  input  logic [ID_W-1:0]            callback_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [KIND_W-1:0]          result_kind,
  output logic [ID_W-1:0]            event_id,
  output logic [RCNT_W-1:0]          removed_count,
  output logic                       last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IW    = INTERVAL_BITS;

  // entry memories
  logic [IW-1:0]              mem_interval  [SLOTS];
  logic [IW-1:0]              mem_remaining [SLOTS];
  logic signed [REPEAT_W-1:0] mem_repeats   [SLOTS];
  logic [ID_W-1:0]            mem_owner     [SLOTS];

  // registered read of the entry under the walk
  logic [IW-1:0]              rd_interval;
  logic [IW-1:0]              rd_remaining;
  logic signed [REPEAT_W-1:0] rd_repeats;
  logic [ID_W-1:0]            rd_owner;

  // latched item
  logic [CMD_W-1:0]           op;
  logic [IW-1:0]              ival;
  logic signed [REPEAT_W-1:0] reps;
  logic [ID_W-1:0]            id;

  // walk state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] wr_ptr;
  logic [CNT_W-1:0] removed;
  logic [IDX_W-1:0] rd_idx;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  logic             full;
  logic             out_free;
  logic             is_tick;
  logic             fire;
  logic signed [REPEAT_W-1:0] rep_dec;
  logic             keep;
  logic             match;
  logic [IW-1:0]    new_remaining;
  logic signed [REPEAT_W-1:0] new_repeats;
  logic [CNT_W-1:0] rd_next;
  logic             at_end;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IW-1:0]    wr_interval;
  logic [IW-1:0]    wr_remaining;
  logic signed [REPEAT_W-1:0] wr_repeats;
  logic [ID_W-1:0]  wr_owner;
  logic             emit;
  logic [KIND_W-1:0] emit_kind;
  logic [ID_W-1:0]  emit_id;
  logic [RCNT_W-1:0] emit_cnt;
  logic             emit_last;
  logic [RCNT_W-1:0] removed_sat;

  assign full     = (count == CNT_W'(SLOTS));
  assign out_free = !out_valid || !out_stall;
  assign is_tick  = (op == CMD_TICK);

  // per-entry update for the walk
  assign fire          = (rd_remaining <= IW'(1));
  assign rep_dec       = (rd_repeats > 0) ? rd_repeats - 16'sd1 : rd_repeats;
  assign match         = (rd_owner == id);
  assign keep          = is_tick ? (!fire || rep_dec != 0) : !match;
  assign new_remaining = !is_tick ? rd_remaining :
                         fire     ? rd_interval  : rd_remaining - IW'(1);
  // repeats only count down when the entry fires
  assign new_repeats   = (is_tick && fire) ? rep_dec : rd_repeats;

  assign rd_next = CNT_W'(rd_idx) + CNT_W'(1);
  assign at_end  = (rd_next == count);

  // status to controller
  assign stat.op         = op;
  assign stat.empty      = (count == '0);
  assign stat.out_free   = out_free;
  assign stat.need_out   = is_tick && fire && pend_valid;
  assign stat.at_end     = at_end;
  assign stat.pend_valid = pend_valid;

  // memory port control
  assign rd_en   = ctrl.prime || (ctrl.step && !at_end);
  assign rd_addr = ctrl.prime ? '0 : rd_next[IDX_W-1:0];
  assign wr_en   = (ctrl.add && !full) || (ctrl.step && keep);
  assign wr_addr = ctrl.add ? count[IDX_W-1:0] : wr_ptr[IDX_W-1:0];
  assign wr_interval  = ctrl.add ? ival : rd_interval;
  assign wr_remaining = ctrl.add ? ival : new_remaining;
  assign wr_repeats   = ctrl.add ? reps : new_repeats;
  assign wr_owner     = ctrl.add ? id   : rd_owner;

  // entry storage, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_interval[wr_addr]  <= wr_interval;
      mem_remaining[wr_addr] <= wr_remaining;
      mem_repeats[wr_addr]   <= wr_repeats;
      mem_owner[wr_addr]     <= wr_owner;
    end
    if (rd_en) begin
      rd_interval  <= mem_interval[rd_addr];
      rd_remaining <= mem_remaining[rd_addr];
      rd_repeats   <= mem_repeats[rd_addr];
      rd_owner     <= mem_owner[rd_addr];
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op   <= cmd;
      ival <= IW'(interval_ms);
      reps <= repeat_count;
      id   <= callback_id;
    end
  end

  // walk bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      wr_ptr     <= '0;
      removed    <= '0;
      rd_idx     <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        wr_ptr     <= '0;
        removed    <= '0;
        pend_valid <= 1'b0;
      end
      if (ctrl.prime) begin
        rd_idx <= '0;
      end
      if (ctrl.step) begin
        if (!at_end) rd_idx <= rd_next[IDX_W-1:0];
        if (keep) wr_ptr <= wr_ptr + CNT_W'(1);
        if (!is_tick && match) removed <= removed + CNT_W'(1);
        if (is_tick && fire) pend_valid <= 1'b1;
      end
      if (ctrl.add && !full) begin
        count <= count + CNT_W'(1);
      end
      if (ctrl.finish) begin
        count <= wr_ptr;
      end
    end
  end

  // held expiry, sent once the next one or the end of the walk is known
  always_ff @(posedge clk) begin
    if (ctrl.step && is_tick && fire) begin
      pend_id <= rd_owner;
    end
  end

  assign removed_sat = (32'(removed) > 32'(RCNT_MAX)) ? RCNT_MAX : RCNT_W'(removed);

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_ADDED;
    emit_id   = id;
    emit_cnt  = '0;
    emit_last = 1'b1;
    if (ctrl.add) begin
      emit      = 1'b1;
      emit_kind = full ? KIND_REJECTED : KIND_ADDED;
    end else if (ctrl.step && is_tick && fire && pend_valid) begin
      emit      = 1'b1;
      emit_kind = KIND_EXPIRY;
      emit_id   = pend_id;
      emit_last = 1'b0;
    end else if (ctrl.finish && !is_tick) begin
      emit      = 1'b1;
      emit_kind = KIND_REMOVED;
      emit_cnt  = removed_sat;
    end else if (ctrl.finish && pend_valid) begin
      emit      = 1'b1;
      emit_kind = KIND_EXPIRY;
      emit_id   = pend_id;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind   <= emit_kind;
      event_id      <= emit_id;
      removed_count <= emit_cnt;
      last          <= emit_last;
    end
  end

  // table never holds more entries than slots
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count above slot count");

  // compaction write never overtakes the read
  assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> wr_ptr <= CNT_W'(rd_idx))
    else $error("compaction write passed read index");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a pending item");

endmodule

[design/repeating_timer_table_unit.sv]
// Top level of the repeating timer table: controller plus datapath
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// in       | receive   | in_valid/in_stall  | cmd, interval_ms, repeat_count, callback_id
// out      | send      | out_valid/out_stall| result_kind, event_id, removed_count, last
//
// add passes through accept and add; remove and tick pass through accept, prime, one
// walk step per stored entry of the single-read-port entry memory, and finish.
// an empty remove runs accept and finish; an empty tick or unknown command only accept.
// a stalled output holds the walk only at steps that must hand over an item.
// rst is synchronous; it empties the table, clears out_valid, stalls input.
`timescale 1ns / 1ps

module repeating_timer_table_unit import rtt_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [IVAL_W-1:0]          interval_ms,
  input  logic signed [REPEAT_W-1:0] repeat_count,
  input  logic [ID_W-1:0]            callback_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [KIND_W-1:0]          result_kind,
  output logic [ID_W-1:0]            event_id,
  output logic [RCNT_W-1:0]          removed_count,
  output logic                       last
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencing
  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // table and result path
  rtt_datapath #(
    .SLOTS         (SLOTS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cmd           (cmd),
    .interval_ms   (interval_ms),
    .repeat_count  (repeat_count),
    .callback_id   (callback_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .event_id      (event_id),
    .removed_count (removed_count),
    .last          (last)
  );

endmodule
